// ----- design/lnps_pkg.sv -----
// Package for the last-note priority stack: event codes, cell op codes,
// cell data and control structs. No dependencies.
`timescale 1ns / 1ps

package lnps_pkg;

  localparam int unsigned NOTE_W = 7;
  localparam int unsigned VEL_W  = 7;

  localparam logic [VEL_W-1:0] FULL_VELOCITY = 7'd127;

  // Incoming event kinds
  typedef enum logic [1:0] {
    REQ_NOTE_ON  = 2'd0,
    REQ_NOTE_OFF = 2'd1,
    REQ_ALL_OFF  = 2'd2,
    REQ_OTHER    = 2'd3
  } req_kind_e;

  // Voice actions
  typedef enum logic {
    ACT_START   = 1'b0,
    ACT_RELEASE = 1'b1
  } voice_act_e;

  // Operation broadcast to every cell of the row
  typedef enum logic [1:0] {
    OP_HOLD  = 2'd0,
    OP_PUSH  = 2'd1,
    OP_POP   = 2'd2,
    OP_CLEAR = 2'd3
  } cell_op_e;

  // Pending result kind held between update and presentation
  typedef enum logic [1:0] {
    RES_START   = 2'd0,
    RES_NEWEST  = 2'd1,
    RES_RELEASE = 2'd2
  } res_kind_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EMIT = 1'b1
  } lnps_state_e;

  typedef struct packed {
    logic              valid;
    logic [NOTE_W-1:0] note;
  } cell_t;

  typedef struct packed {
    cell_op_e          op;
    logic [NOTE_W-1:0] key;
  } lnps_ctrl_t;

endpackage

// ----- design/lnps_if.sv -----
// Valid/ready channel interfaces for MIDI events in and voice commands out.
// Depends on lnps_pkg for field widths.
`timescale 1ns / 1ps

interface lnps_req_if
  import lnps_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [1:0]        req_type;
  logic [NOTE_W-1:0] note_number;
  logic [VEL_W-1:0]  velocity;

  modport source (output valid, output req_type, output note_number, output velocity,
                  input ready);
  modport sink   (input valid, input req_type, input note_number, input velocity,
                  output ready);
endinterface

interface lnps_rsp_if
  import lnps_pkg::*;
();
  logic              valid;
  logic              ready;
  logic              voice_action;
  logic [NOTE_W-1:0] voice_note;
  logic [VEL_W-1:0]  voice_velocity;

  modport source (output valid, output voice_action, output voice_note,
                  output voice_velocity, input ready);
  modport sink   (input valid, input voice_action, input voice_note,
                  input voice_velocity, output ready);
endinterface

// ----- design/lnps_cell.sv -----
// One slot of the note stack: holds a note and a valid bit, shifts to or
// from its neighbours on push/pop. Depends on lnps_pkg.
`timescale 1ns / 1ps

module lnps_cell
  import lnps_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  lnps_ctrl_t ctrl_i,
  input  cell_t      newer_i,  // neighbour towards the newest end
  input  cell_t      older_i,  // neighbour towards the oldest end
  input  logic       seen_i,   // key matched in a newer cell
  output logic       seen_o,
  output cell_t      data_o
);

  logic              valid_q, valid_d;
  logic [NOTE_W-1:0] note_q, note_d;
  logic              hit;

  assign hit    = valid_q && (note_q == ctrl_i.key);
  assign seen_o = seen_i | hit;
  assign data_o = '{valid: valid_q, note: note_q};

  always_comb begin
    valid_d = valid_q;
    note_d  = note_q;
    case (ctrl_i.op)
      OP_PUSH: begin
        // shift older until the earlier copy of the key is overwritten
        if (!seen_i) begin
          valid_d = newer_i.valid;
          note_d  = newer_i.note;
        end
      end
      OP_POP: begin
        // close the gap left by the removed key
        if (seen_i || hit) begin
          valid_d = older_i.valid;
          note_d  = older_i.note;
        end
      end
      OP_CLEAR: valid_d = 1'b0;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    note_q <= note_d;
  end

endmodule

// ----- design/lnps_chain.sv -----
// Row of NOTE_SLOTS stack cells, newest at index 0, oldest at the far end.
// Depends on lnps_pkg and lnps_cell.
`timescale 1ns / 1ps

module lnps_chain
  import lnps_pkg::*;
#(
  parameter int unsigned NOTE_SLOTS = 128
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  lnps_ctrl_t ctrl_i,
  output cell_t      head_o
);

  cell_t cells [NOTE_SLOTS];
  logic  seen  [NOTE_SLOTS+1];

  assign seen[0] = 1'b0;
  assign head_o  = cells[0];

  for (genvar i = 0; i < NOTE_SLOTS; i++) begin : g_cell
    cell_t newer, older;

    if (i == 0) begin : g_first
      assign newer = '{valid: 1'b1, note: ctrl_i.key};
    end else begin : g_mid_newer
      assign newer = cells[i-1];
    end

    if (i == NOTE_SLOTS - 1) begin : g_last
      assign older = '{valid: 1'b0, note: '0};
    end else begin : g_mid_older
      assign older = cells[i+1];
    end

    lnps_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (ctrl_i),
      .newer_i(newer),
      .older_i(older),
      .seen_i (seen[i]),
      .seen_o (seen[i+1]),
      .data_o (cells[i])
    );
  end

endmodule

// ----- design/last_note_priority_stack_top.sv -----
// Last-note priority stack for a mono voice. Depends on lnps_pkg, lnps_if, lnps_chain.
// A note or all-off transaction updates the row at the accept edge; in the emit state the
// output register then loads the pending note or the head cell once its slot is free or taken.
// No new event is taken until that load; a result waiting at the output holds off the load
// and so the input. Other events give nothing and leave the block idle and ready.
// Reset: asynchronous, active low; empties the stack (valid bits) and the output slot.
`timescale 1ns / 1ps

module last_note_priority_stack_top
  import lnps_pkg::*;
#(
  parameter int unsigned NOTE_SLOTS = 128
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  lnps_req_if.sink    req_i,
  lnps_rsp_if.source  rsp_o
);

  // ---------------------------------------------------------------------
  // Control state
  // ---------------------------------------------------------------------
  lnps_state_e       state_q, state_d;
  res_kind_e         res_q, res_d;
  logic [NOTE_W-1:0] pend_note_q;
  logic [VEL_W-1:0]  pend_vel_q;

  // Output register: a finished result may wait here while a new event is taken
  logic              out_valid_q, out_valid_d;
  logic              out_action_q;
  logic [NOTE_W-1:0] out_note_q;
  logic [VEL_W-1:0]  out_vel_q;

  logic       accept;
  logic       has_result;
  logic       out_load;
  lnps_ctrl_t ctrl;
  cell_t      head;
  req_kind_e  kind;

  assign kind   = req_kind_e'(req_i.req_type);
  assign accept = req_i.valid && req_i.ready;

  // ---------------------------------------------------------------------
  // Event decode: note on with zero velocity is a note off
  // ---------------------------------------------------------------------
  always_comb begin
    res_d      = res_q;
    has_result = 1'b1;
    ctrl.op    = OP_HOLD;
    ctrl.key   = req_i.note_number;
    case (kind)
      REQ_NOTE_ON: begin
        if (req_i.velocity != '0) begin
          ctrl.op = OP_PUSH;
          res_d   = RES_START;
        end else begin
          ctrl.op = OP_POP;
          res_d   = RES_NEWEST;
        end
      end
      REQ_NOTE_OFF: begin
        ctrl.op = OP_POP;
        res_d   = RES_NEWEST;
      end
      REQ_ALL_OFF: begin
        ctrl.op = OP_CLEAR;
        res_d   = RES_RELEASE;
      end
      default: has_result = 1'b0;
    endcase
    if (!accept) begin
      ctrl.op = OP_HOLD;
    end
  end

  // ---------------------------------------------------------------------
  // Cell row: removal and insertion happen in the accept cycle
  // ---------------------------------------------------------------------
  lnps_chain #(
    .NOTE_SLOTS(NOTE_SLOTS)
  ) u_chain (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .ctrl_i(ctrl),
    .head_o(head)
  );

  // ---------------------------------------------------------------------
  // Sequencer: next state
  // ---------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (accept && has_result) state_d = ST_EMIT;
      ST_EMIT: if (out_load) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // Sequencer: outputs
  always_comb begin
    req_i.ready = 1'b0;
    out_load    = 1'b0;
    case (state_q)
      ST_IDLE: req_i.ready = 1'b1;
      ST_EMIT: out_load = !out_valid_q || rsp_o.ready;
      default: ;
    endcase
  end

  assign out_valid_d = out_load || (out_valid_q && !rsp_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      res_q       <= RES_RELEASE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (accept) begin
        res_q <= res_d;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      pend_note_q <= req_i.note_number;
      pend_vel_q  <= req_i.velocity;
    end
    if (out_load) begin
      case (res_q)
        RES_START: begin
          out_action_q <= ACT_START;
          out_note_q   <= pend_note_q;
          out_vel_q    <= pend_vel_q;
        end
        RES_NEWEST: begin
          // retrigger on the newest remaining note, or release if empty
          if (head.valid) begin
            out_action_q <= ACT_START;
            out_note_q   <= head.note;
            out_vel_q    <= FULL_VELOCITY;
          end else begin
            out_action_q <= ACT_RELEASE;
            out_note_q   <= '0;
            out_vel_q    <= '0;
          end
        end
        default: begin
          out_action_q <= ACT_RELEASE;
          out_note_q   <= '0;
          out_vel_q    <= '0;
        end
      endcase
    end
  end

  assign rsp_o.valid          = out_valid_q;
  assign rsp_o.voice_action   = out_action_q;
  assign rsp_o.voice_note     = out_note_q;
  assign rsp_o.voice_velocity = out_vel_q;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  // A pushed note is the newest entry in the next cycle
  a_push_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && ctrl.op == OP_PUSH) |=>
      (head.valid && head.note == $past(req_i.note_number)))
    else $error("pushed note not at head of stack");

  // Clearing empties the stack
  a_clear_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && ctrl.op == OP_CLEAR) |=> !head.valid)
    else $error("stack not empty after clear");

  // A result only appears when a pending event is presented
  a_out_from_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_EMIT))
    else $error("result raised without pending event");

  // A result on release carries no note or velocity
  a_release_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_action_q == ACT_RELEASE) |-> (out_note_q == '0 && out_vel_q == '0))
    else $error("release result with non-zero payload");

endmodule

// ----- tb/lnps_voice_checker.sv -----
// Scoreboard for the last-note priority stack: watches both channels, predicts
// each voice command and compares it. Depends on lnps_pkg and lnps_if.
`timescale 1ns / 1ps

module lnps_voice_checker
  import lnps_pkg::*;
#(
  parameter int unsigned NOTE_SLOTS = 128
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  lnps_req_if         req_mon,
  lnps_rsp_if         rsp_mon,
  output int unsigned err_count_o,
  output int unsigned outstanding_o
);

  typedef struct packed {
    voice_act_e        act;
    logic [NOTE_W-1:0] note;
    logic [VEL_W-1:0]  vel;
  } voice_cmd_t;

  logic [NOTE_W-1:0] held_stack[$];    // oldest first, newest last
  voice_cmd_t        pending_cmds[$];
  int unsigned       err_count = 0;

  assign err_count_o = err_count;

  // Prints are capped so a badly broken build cannot flood the log.
  task automatic report_mismatch(input string msg);
    err_count++;
    if (err_count <= 40) $display("[%0t] MISMATCH: %s", $time, msg);
  endtask

  function automatic void drop_held(input logic [NOTE_W-1:0] note);
    for (int i = 0; i < held_stack.size(); i++) begin
      if (held_stack[i] == note) begin
        held_stack.delete(i);
        return;
      end
    end
  endfunction

  // Updates the held list and gives the voice command, if the event makes one.
  function automatic bit predict_voice(input req_kind_e kind, input logic [NOTE_W-1:0] note,
                                       input logic [VEL_W-1:0] vel, output voice_cmd_t cmd);
    cmd = '{ACT_RELEASE, '0, '0};
    case (kind)
      REQ_NOTE_ON, REQ_NOTE_OFF: begin
        drop_held(note);
        if (kind == REQ_NOTE_ON && vel != '0) begin
          if (held_stack.size() >= NOTE_SLOTS) void'(held_stack.pop_front());
          held_stack.insert(held_stack.size(), note);
          cmd = '{ACT_START, note, vel};
        end else if (held_stack.size() != 0) begin
          cmd = '{ACT_START, held_stack[$], FULL_VELOCITY};
        end
        return 1'b1;
      end
      REQ_ALL_OFF: begin
        held_stack.delete();
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    voice_cmd_t exp_cmd;
    voice_cmd_t new_cmd;
    if (!rst_ni) begin
      held_stack.delete();
      pending_cmds.delete();
      outstanding_o <= 0;
    end else begin
      // a result never belongs to a request taken at the same edge
      if (rsp_mon.valid && rsp_mon.ready) begin
        if (pending_cmds.size() == 0) begin
          report_mismatch($sformatf("unexpected result act=%0d note=%0d vel=%0d",
                                    rsp_mon.voice_action, rsp_mon.voice_note,
                                    rsp_mon.voice_velocity));
        end else begin
          exp_cmd = pending_cmds.pop_front();
          if (rsp_mon.voice_action !== exp_cmd.act)
            report_mismatch($sformatf("voice_action %0d, expected %0d",
                                      rsp_mon.voice_action, exp_cmd.act));
          if (rsp_mon.voice_note !== exp_cmd.note)
            report_mismatch($sformatf("voice_note %0d, expected %0d",
                                      rsp_mon.voice_note, exp_cmd.note));
          if (rsp_mon.voice_velocity !== exp_cmd.vel)
            report_mismatch($sformatf("voice_velocity %0d, expected %0d",
                                      rsp_mon.voice_velocity, exp_cmd.vel));
        end
      end
      if (req_mon.valid && req_mon.ready) begin
        if (predict_voice(req_kind_e'(req_mon.req_type), req_mon.note_number,
                          req_mon.velocity, new_cmd))
          pending_cmds.insert(pending_cmds.size(), new_cmd);
      end
      outstanding_o <= pending_cmds.size();
    end
  end

endmodule

// ----- tb/last_note_priority_stack_top_tb.sv -----
// Top of the last-note priority stack testbench: clock, reset, MIDI event
// stimulus, receiver back-pressure and verdict. Depends on lnps_pkg, lnps_if,
// lnps_voice_checker and the block itself.
`timescale 1ns / 1ps

module last_note_priority_stack_top_tb;
  import lnps_pkg::*;

  localparam int unsigned CLK_PERIOD      = 20;
  // A short stack, so that the drop-oldest path on a full list is reachable.
  localparam int unsigned SLOTS           = 8;
  localparam int unsigned RANDOM_EVENTS   = 480;
  localparam int unsigned PHASE_EVENTS    = RANDOM_EVENTS / 3;
  localparam int unsigned HOLD_OFF_CYCLES = 120;
  localparam int unsigned DRAIN_CYCLES    = 8;
  // Far above the worst-case length of the whole run.
  localparam int unsigned CYCLE_LIMIT     = 200000;

  logic clk_i;
  logic rst_ni;

  lnps_req_if req_ch ();
  lnps_rsp_if rsp_ch ();

  int unsigned err_count;
  int unsigned outstanding;
  int unsigned cycle_count   = 0;
  int unsigned send_idle_pct = 35;
  int unsigned rcv_idle_pct  = 48;
  // Bumped by the stimulus to ask the receiver for one long hold-off.
  int unsigned hold_off_asked = 0;

  last_note_priority_stack_top #(
    .NOTE_SLOTS(SLOTS)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_ch),
    .rsp_o (rsp_ch)
  );

  lnps_voice_checker #(
    .NOTE_SLOTS(SLOTS)
  ) u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_mon      (req_ch),
    .rsp_mon      (rsp_ch),
    .err_count_o  (err_count),
    .outstanding_o(outstanding)
  );

  initial clk_i = 1'b0;
  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Watchdog: a hung handshake or a lost result ends up here.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[%0t] timeout after %0d cycles", $time, cycle_count);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: random ready, plus one long hold-off on request. The hold-off is
  // timed here, so the sender keeps offering transactions meanwhile and the
  // block has to fill up and drop its own ready.
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned hold_off_done;
    hold_off_done = 0;
    rsp_ch.ready  = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_off_done != hold_off_asked) begin
        hold_off_done = hold_off_asked;
        rsp_ch.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk_i);
      end
      rsp_ch.ready <= !(rcv_idle_pct != 0 && $urandom_range(99) < rcv_idle_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Sender helpers
  // ---------------------------------------------------------------------------

  // Offers one event and returns at the edge that takes it. valid is only
  // dropped when a gap is chosen, so back-to-back transactions never see a
  // fall and a rise in the same step.
  task automatic send_event(input req_kind_e kind, input logic [NOTE_W-1:0] note,
                            input logic [VEL_W-1:0] vel);
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    req_ch.valid       <= 1'b1;
    req_ch.req_type    <= kind;
    req_ch.note_number <= note;
    req_ch.velocity    <= vel;
    do @(posedge clk_i); while (!req_ch.ready);
  endtask

  // Sender stands still until every predicted command has come out.
  task automatic wait_idle();
    req_ch.valid <= 1'b0;
    do @(posedge clk_i); while (outstanding != 0);
  endtask

  // Random MIDI traffic. Most notes come from a narrow pool, so note-offs
  // usually hit held notes and the short stack overflows now and then; the
  // rest roam the whole range to toggle every bit.
  task automatic send_random(input logic [NOTE_W-1:0] pool_base, output bit counted);
    int unsigned       pick;
    req_kind_e         kind;
    logic [NOTE_W-1:0] note;
    logic [VEL_W-1:0]  vel;
    pick = $urandom_range(99);
    if (pick < 50)      kind = REQ_NOTE_ON;
    else if (pick < 84) kind = REQ_NOTE_OFF;
    else if (pick < 90) kind = REQ_ALL_OFF;
    else                kind = REQ_OTHER;
    if ($urandom_range(99) < 85) note = pool_base + NOTE_W'($urandom_range(11));
    else                         note = NOTE_W'($urandom_range(127));
    // zero velocity on a note-on now and then: must act as a note-off
    if (kind == REQ_NOTE_ON && $urandom_range(99) >= 8) vel = VEL_W'($urandom_range(127, 1));
    else if (kind == REQ_NOTE_ON)                       vel = '0;
    else                                                vel = VEL_W'($urandom_range(127));
    send_event(kind, note, vel);
    counted = (kind != REQ_OTHER);
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus and verdict
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned       sent;
    bit                counted;
    logic [NOTE_W-1:0] pool_base;

    rst_ni             = 1'b0;
    req_ch.valid       = 1'b0;
    req_ch.req_type    = REQ_OTHER;
    req_ch.note_number = '0;
    req_ch.velocity    = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: field extremes, re-press of a held note, release of a note
    // that is not the newest, zero-velocity note-on, note-off of a note not
    // held, release on an empty list, all-off, ignored event kind.
    send_event(REQ_NOTE_ON,  7'd0,   7'd127);
    send_event(REQ_NOTE_ON,  7'd127, 7'd1);
    send_event(REQ_NOTE_ON,  7'd60,  7'd64);
    send_event(REQ_NOTE_ON,  7'd0,   7'd100);  // moves 0 to the newest end
    send_event(REQ_NOTE_OFF, 7'd60,  7'd0);    // not newest: retrigger on 0
    send_event(REQ_NOTE_ON,  7'd127, 7'd0);    // treated as note-off
    send_event(REQ_NOTE_OFF, 7'd99,  7'd127);  // not held
    send_event(REQ_OTHER,    7'd85,  7'd42);   // no result
    send_event(REQ_NOTE_OFF, 7'd0,   7'd0);    // list empties: release
    send_event(REQ_NOTE_OFF, 7'd42,  7'd0);    // release on empty list
    send_event(REQ_ALL_OFF,  7'd127, 7'd127);
    // One note past a full stack: the oldest (10) is dropped.
    for (int n = 0; n <= SLOTS; n++)
      send_event(REQ_NOTE_ON, NOTE_W'(10 + n), VEL_W'(20 + 11 * n));
    send_event(REQ_NOTE_OFF, 7'd10, 7'd5);     // the dropped note: no longer held
    send_event(REQ_ALL_OFF,  7'd0,  7'd0);
    wait_idle();

    // Random part in three idling regimes; the sender pauses until the block
    // has drained at each change.
    pool_base = '0;
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 35;
          rcv_idle_pct  = 48;
        end
        1: begin
          send_idle_pct = 48;
          rcv_idle_pct  = 35;
        end
        default: begin
          send_idle_pct = 0;
          rcv_idle_pct  = 0;
          // long receiver hold-off while the sender runs flat out
          hold_off_asked <= hold_off_asked + 1;
        end
      endcase
      sent = 0;
      while (sent < PHASE_EVENTS) begin
        if (sent % 40 == 0) pool_base = NOTE_W'($urandom_range(116));
        send_random(pool_base, counted);
        if (counted) sent++;
      end
      wait_idle();
    end

    // Everything predicted has arrived; wait out DRAIN_CYCLES in case something stray comes out.
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (err_count == 0) $display("Testbench completed without errors");
    else                $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
